// ===== hw/rtl/rrsg_pkg.sv =====
// Shared types, codes and the square-root step for the rounded rectangle span generator.
package rrsg_pkg;

	localparam int MaxRadius = 30;
	localparam int CoordBits = 12;
	localparam logic [11:0] CoordMask = 12'((64'd1 << CoordBits) - 64'd1);

	// configuration register indexes
	localparam logic [1:0] RegScreenWidth  = 2'd0;
	localparam logic [1:0] RegScreenHeight = 2'd1;

	// span kinds
	localparam logic [2:0] KindWhole  = 3'd0;
	localparam logic [2:0] KindCenter = 3'd1;
	localparam logic [2:0] KindLeft   = 3'd2;
	localparam logic [2:0] KindRight  = 3'd3;
	localparam logic [2:0] KindRow    = 3'd4;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [11:0] w;
		logic [11:0] h;
		logic [4:0]  r;
		logic [2:0]  kind;
		logic [4:0]  dy;
		logic        bottom;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic [11:0] rem;
		logic [11:0] root;
	} sq_t;

	// one digit of the restoring integer square root
	function automatic sq_t sq_step(input sq_t s, input logic [11:0] b);
		sq_t o;
		logic [12:0] trial;
		trial = {1'b0, s.root} + {1'b0, b};
		o = s;
		if ({1'b0, s.rem} >= trial) begin
			o.rem  = s.rem - trial[11:0];
			o.root = (s.root >> 1) + b;
		end else begin
			o.root = s.root >> 1;
		end
		return o;
	endfunction

endpackage

// ===== hw/rtl/rounded_rect_span_generator.sv =====
// Top level: rectangle normalize/clip pipeline, span sequencer and square-root span pipeline.
// Pipeline: 3 front stages, sequencer load, 4 span stages, output register.
// Throughput: one span per cycle while out_ready does not stall the output, so an item
// yields 1 span (zero radius) or 2r+3 spans, at most 63, limited by the sequencer.
// Up to three items wait in the front stages while the sequencer is busy.
// Reset: asynchronous, clears all valid bits and the sequencer; screen size to 1920x1080.
module rounded_rect_span_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [11:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [13:0] rect_left,
	input  logic signed [13:0] rect_top,
	input  logic signed [13:0] rect_width,
	input  logic signed [13:0] rect_height,
	input  logic [9:0]         corner_radius,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [11:0]        span_x,
	output logic [11:0]        span_y,
	output logic [11:0]        span_w,
	output logic [11:0]        span_h,
	output logic               last_span
);

	// configuration
	logic [11:0] screen_width_q, screen_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= 12'd1920;
			screen_height_q <= 12'd1080;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rrsg_pkg::RegScreenWidth:  screen_width_q  <= cfg_data;
				rrsg_pkg::RegScreenHeight: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [14:0] maxw, maxh;
	assign maxw = (screen_width_q == 12'd0) ? 15'sd1 : $signed({3'b000, screen_width_q});
	assign maxh = (screen_height_q == 12'd0) ? 15'sd1 : $signed({3'b000, screen_height_q});

	// handshake chain
	logic en, last_issue, load_seq, busy_q;
	logic ready_s1, ready_s2, ready_s3;
	logic valid_s1, valid_s2, valid_s3;

	// stage 1: normalize extents
	logic signed [14:0] xs_s1, xe_s1, ys_s1, ye_s1;
	logic               zero_s1;
	logic [4:0]         req_s1;
	logic signed [14:0] l_e, t_e, w_e, h_e;

	assign l_e = 15'(rect_left);
	assign t_e = 15'(rect_top);
	assign w_e = 15'(rect_width);
	assign h_e = 15'(rect_height);
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			xs_s1   <= (w_e < 0) ? l_e + w_e : l_e;
			xe_s1   <= (w_e < 0) ? l_e : l_e + w_e;
			ys_s1   <= (h_e < 0) ? t_e + h_e : t_e;
			ye_s1   <= (h_e < 0) ? t_e : t_e + h_e;
			zero_s1 <= (rect_width == 14'sd0) || (rect_height == 14'sd0);
			req_s1  <= (corner_radius > 10'(rrsg_pkg::MaxRadius)) ?
				5'(rrsg_pkg::MaxRadius) : corner_radius[4:0];
		end
	end

	// stage 2: clip to the screen
	logic signed [14:0] x0, x1, y0, y1;
	logic               empty_c;
	logic [11:0]        x_s2, y_s2, w_s2, h_s2;
	logic [4:0]         req_s2;
	logic               empty_s2;

	assign x0 = (xs_s1 < 0) ? 15'sd0 : xs_s1;
	assign y0 = (ys_s1 < 0) ? 15'sd0 : ys_s1;
	assign x1 = (xe_s1 < maxw) ? xe_s1 : maxw;
	assign y1 = (ye_s1 < maxh) ? ye_s1 : maxh;
	assign empty_c = zero_s1 || (x1 <= x0) || (y1 <= y0);
	assign ready_s1 = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			x_s2     <= x0[11:0];
			y_s2     <= y0[11:0];
			w_s2     <= 12'(x1 - x0);
			h_s2     <= 12'(y1 - y0);
			req_s2   <= req_s1;
			empty_s2 <= empty_c;
		end
	end

	// stage 3: bound the radius; empty items drop out here
	logic [11:0] x_s3, y_s3, w_s3, h_s3;
	logic [4:0]  r_s3, r_c;
	logic [4:0]  r_tmp;

	always_comb begin
		r_tmp = req_s2;
		if ({7'b0, r_tmp} > {1'b0, w_s2[11:1]}) r_tmp = w_s2[5:1];
		if ({7'b0, r_tmp} > {1'b0, h_s2[11:1]}) r_tmp = h_s2[5:1];
		r_c = r_tmp;
	end

	assign ready_s2 = !valid_s2 || ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2 && !empty_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			x_s3 <= x_s2;
			y_s3 <= y_s2;
			w_s3 <= w_s2;
			h_s3 <= h_s2;
			r_s3 <= r_c;
		end
	end

	// sequencer: one span token per cycle for the held item, while the output is not stalled
	logic [11:0] cx_q, cy_q, cw_q, ch_q;
	logic [4:0]  cr_q;
	logic [5:0]  cnt_q, idx_q, j;

	assign en         = !out_valid || out_ready;
	assign last_issue = (idx_q == cnt_q);
	assign load_seq   = valid_s3 && (!busy_q || (en && last_issue));
	assign ready_s3   = !valid_s3 || load_seq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load_seq) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (en && busy_q) begin
			if (last_issue) busy_q <= 1'b0;
			else idx_q <= idx_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_seq) begin
			cx_q  <= x_s3;
			cy_q  <= y_s3;
			cw_q  <= w_s3;
			ch_q  <= h_s3;
			cr_q  <= r_s3;
			cnt_q <= (r_s3 == 5'd0) ? 6'd0 : {r_s3, 1'b0} + 6'd2;
		end
	end

	// token build and the two squares
	rrsg_pkg::tok_t tok_c;
	logic [5:0]     k2;

	assign j  = idx_q - 6'd3;
	assign k2 = {cr_q, 1'b0} - {j[5:1], 1'b0} - 6'd1;

	always_comb begin
		tok_c.x      = cx_q;
		tok_c.y      = cy_q;
		tok_c.w      = cw_q;
		tok_c.h      = ch_q;
		tok_c.r      = cr_q;
		tok_c.dy     = j[5:1];
		tok_c.bottom = j[0];
		tok_c.last   = last_issue;
		if (cr_q == 5'd0)        tok_c.kind = rrsg_pkg::KindWhole;
		else if (idx_q == 6'd0)  tok_c.kind = rrsg_pkg::KindCenter;
		else if (idx_q == 6'd1)  tok_c.kind = rrsg_pkg::KindLeft;
		else if (idx_q == 6'd2)  tok_c.kind = rrsg_pkg::KindRight;
		else                     tok_c.kind = rrsg_pkg::KindRow;
	end

	logic           valid_s4, valid_s5, valid_s6, valid_s7;
	rrsg_pkg::tok_t tok_s4, tok_s5, tok_s6, tok_s7;
	logic [9:0]     rsq_s4;
	logic [11:0]    k2sq_s4;
	rrsg_pkg::sq_t  sq_s5, sq_s6, sq_in5, sq_c5, sq_c6, sq_c7;
	logic [4:0]     inset_s7, dx_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s4  <= busy_q;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			out_valid <= valid_s7;
		end
	end

	// square root: two digits per stage
	assign sq_in5.rem  = {rsq_s4, 2'b00} - k2sq_s4;
	assign sq_in5.root = '0;
	assign sq_c5 = rrsg_pkg::sq_step(rrsg_pkg::sq_step(sq_in5, 12'h400), 12'h100);
	assign sq_c6 = rrsg_pkg::sq_step(rrsg_pkg::sq_step(sq_s5, 12'h040), 12'h010);
	assign sq_c7 = rrsg_pkg::sq_step(rrsg_pkg::sq_step(sq_s6, 12'h004), 12'h001);
	assign dx_c  = sq_c7.root[5:1];

	// output span formation
	logic [11:0] ox, oy, ow, oh, r12, r2, in12, in2;

	assign r12  = {7'b0, tok_s7.r};
	assign r2   = {6'b0, tok_s7.r, 1'b0};
	assign in12 = {7'b0, inset_s7};
	assign in2  = {6'b0, inset_s7, 1'b0};

	always_comb begin
		case (tok_s7.kind)
			rrsg_pkg::KindCenter: begin
				ox = tok_s7.x + r12;
				oy = tok_s7.y;
				ow = tok_s7.w - r2;
				oh = tok_s7.h;
			end
			rrsg_pkg::KindLeft: begin
				ox = tok_s7.x;
				oy = tok_s7.y + r12;
				ow = r12;
				oh = tok_s7.h - r2;
			end
			rrsg_pkg::KindRight: begin
				ox = tok_s7.x + tok_s7.w - r12;
				oy = tok_s7.y + r12;
				ow = r12;
				oh = tok_s7.h - r2;
			end
			rrsg_pkg::KindRow: begin
				ox = tok_s7.x + in12;
				oy = tok_s7.bottom ? tok_s7.y + tok_s7.h - {7'b0, tok_s7.dy} - 12'd1
				                   : tok_s7.y + {7'b0, tok_s7.dy};
				ow = tok_s7.w - in2;
				oh = 12'd1;
			end
			default: begin
				ox = tok_s7.x;
				oy = tok_s7.y;
				ow = tok_s7.w;
				oh = tok_s7.h;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_s4   <= tok_c;
			rsq_s4   <= {5'b0, cr_q} * {5'b0, cr_q};
			k2sq_s4  <= {6'b0, k2} * {6'b0, k2};
			tok_s5   <= tok_s4;
			sq_s5    <= sq_c5;
			tok_s6   <= tok_s5;
			sq_s6    <= sq_c6;
			tok_s7   <= tok_s6;
			inset_s7 <= (dx_c > tok_s6.r) ? 5'd0 : tok_s6.r - dx_c;
			span_x    <= ox & rrsg_pkg::CoordMask;
			span_y    <= oy & rrsg_pkg::CoordMask;
			span_w    <= ((ow == 12'd0) ? 12'd1 : ow) & rrsg_pkg::CoordMask;
			span_h    <= ((oh == 12'd0) ? 12'd1 : oh) & rrsg_pkg::CoordMask;
			last_span <= tok_s7.last;
		end
	end

endmodule

// ===== tb/sv/tb_rounded_rect_span_generator.sv =====
// Self-checking testbench for the rounded rectangle span generator.
`timescale 1ns / 100ps

module tb_rounded_rect_span_generator;

	localparam int SettleCycles = 24;      // pause after the span queue drains
	// longest quiet stretch: settle pause + config beats + stalls, with wide margin
	localparam int WatchdogLimit = 4000;
	localparam int MaxReports = 10;
	// indexes past the register list; writes to them must change nothing
	localparam logic [1:0] RegSpareA = 2'd2;
	localparam logic [1:0] RegSpareB = 2'd3;

	typedef struct packed {
		logic signed [13:0] left;
		logic signed [13:0] top;
		logic signed [13:0] width;
		logic signed [13:0] height;
		logic [9:0]         radius;
	} rect_req_t;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [11:0] w;
		logic [11:0] h;
		logic        last;
	} span_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [11:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [13:0] rect_left = '0;
	logic signed [13:0] rect_top = '0;
	logic signed [13:0] rect_width = '0;
	logic signed [13:0] rect_height = '0;
	logic [9:0]         corner_radius = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [11:0]        span_x;
	logic [11:0]        span_y;
	logic [11:0]        span_w;
	logic [11:0]        span_h;
	logic               last_span;

	rounded_rect_span_generator u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.rect_left(rect_left), .rect_top(rect_top), .rect_width(rect_width),
		.rect_height(rect_height), .corner_radius(corner_radius),
		.out_valid(out_valid), .out_ready(out_ready),
		.span_x(span_x), .span_y(span_y), .span_w(span_w), .span_h(span_h),
		.last_span(last_span)
	);

	always #10 clk = ~clk;

	// shadow of the screen registers
	logic [11:0] scr_w = 12'd1920;
	logic [11:0] scr_h = 12'd1080;

	rect_req_t rect_queue[$];
	span_t     span_expect[$];
	logic      in_took = 1'b0;
	logic      idling = 1'b1;
	int        in_gap = 0;
	int        out_gap = 0;
	int        rects_queued = 0;
	int        rects_accepted = 0;
	int        rects_clipped_away = 0;
	int        spans_checked = 0;
	int        cfg_writes = 0;
	int        faults = 0;
	int        quiet_cycles = 0;

	function automatic void note_fault(input string msg);
		faults++;
		if (faults <= MaxReports)
			$display("%s", msg);
	endfunction

	function automatic int int_sqrt(input int n);
		int res;
		res = 0;
		while ((res + 1) * (res + 1) <= n)
			res++;
		return res;
	endfunction

	function automatic span_t make_span(input int x, input int y, input int w, input int h);
		span_t s;
		if (w < 1) w = 1;
		if (h < 1) h = 1;
		s.x = 12'(x);
		s.y = 12'(y);
		s.w = 12'(w);
		s.h = 12'(h);
		s.last = 1'b0;
		return s;
	endfunction

	// normalize, clip, bound the radius and list the fill rectangles
	function automatic void predict_spans(input rect_req_t q);
		int l, t, w, h, maxw, maxh, x0, x1, y0, y1, r, k, dx, inset;
		span_t row[$];
		l = $signed(q.left);
		t = $signed(q.top);
		w = $signed(q.width);
		h = $signed(q.height);
		maxw = (scr_w == 0) ? 1 : int'(scr_w);
		maxh = (scr_h == 0) ? 1 : int'(scr_h);
		if (w < 0) begin
			l += w;
			w = -w;
		end
		if (h < 0) begin
			t += h;
			h = -h;
		end
		x0 = (l > 0) ? l : 0;
		y0 = (t > 0) ? t : 0;
		x1 = (l + w < maxw) ? l + w : maxw;
		y1 = (t + h < maxh) ? t + h : maxh;
		if (w == 0 || h == 0 || x1 <= x0 || y1 <= y0) begin
			rects_clipped_away++;
			return;
		end
		l = x0;
		t = y0;
		w = x1 - x0;
		h = y1 - y0;
		r = (q.radius > rrsg_pkg::MaxRadius) ? rrsg_pkg::MaxRadius : int'(q.radius);
		if (r > w / 2) r = w / 2;
		if (r > h / 2) r = h / 2;
		if (r == 0) begin
			row.push_back(make_span(l, t, w, h));
		end else begin
			row.push_back(make_span(l + r, t, w - 2 * r, h));
			row.push_back(make_span(l, t + r, r, h - 2 * r));
			row.push_back(make_span(l + w - r, t + r, r, h - 2 * r));
			for (int dy = 0; dy < r; dy++) begin
				k = 2 * (r - dy - 1) + 1;
				dx = int_sqrt(4 * r * r - k * k) / 2;
				inset = r - dx;
				if (inset < 0) inset = 0;
				row.push_back(make_span(l + inset, t + dy, w - 2 * inset, 1));
				row.push_back(make_span(l + inset, t + h - dy - 1, w - 2 * inset, 1));
			end
		end
		row[row.size() - 1].last = 1'b1;
		foreach (row[i])
			span_expect.push_back(row[i]);
	endfunction

	// input driver
	always @(negedge clk) begin
		rect_req_t nxt;
		if (arst_n) begin
			if (in_valid && !in_took) begin
				// beat still pending, hold
			end else if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (idling && rect_queue.size() != 0 && $urandom_range(0, 5) == 0) begin
				in_gap = $urandom_range(1, 10) - 1;
				in_valid <= 1'b0;
			end else if (rect_queue.size() != 0) begin
				nxt = rect_queue.pop_front();
				in_valid <= 1'b1;
				rect_left <= nxt.left;
				rect_top <= nxt.top;
				rect_width <= nxt.width;
				rect_height <= nxt.height;
				corner_radius <= nxt.radius;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output backpressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				out_gap = $urandom_range(1, 10) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		span_t got, want;
		if (arst_n) begin
			in_took <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				predict_spans('{rect_left, rect_top, rect_width, rect_height, corner_radius});
				rects_accepted++;
			end
			if (out_valid && out_ready) begin
				got = '{span_x, span_y, span_w, span_h, last_span};
				if (span_expect.size() == 0) begin
					note_fault($sformatf("unexpected span beat x=%0d y=%0d w=%0d h=%0d last=%0b",
						got.x, got.y, got.w, got.h, got.last));
				end else begin
					want = span_expect.pop_front();
					if (got != want)
						note_fault($sformatf({"span %0d: expected x=%0d y=%0d w=%0d h=%0d last=%0b",
							", got x=%0d y=%0d w=%0d h=%0d last=%0b"}, spans_checked,
							want.x, want.y, want.w, want.h, want.last,
							got.x, got.y, got.w, got.h, got.last));
				end
				spans_checked++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rrsg_pkg::RegScreenWidth:  scr_w = cfg_data;
					rrsg_pkg::RegScreenHeight: scr_h = cfg_data;
					default: ;
				endcase
				cfg_writes++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin
		wait (arst_n);
		while (quiet_cycles < WatchdogLimit)
			@(posedge clk);
		$display("timeout: no beat for %0d cycles, %0d spans outstanding",
			WatchdogLimit, span_expect.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_rect(input int l, input int t, input int w, input int h, input int r);
		rect_queue.push_back('{14'(l), 14'(t), 14'(w), 14'(h), 10'(r)});
		rects_queued++;
	endtask

	// mostly rectangles landing on the screen, the rest raw bit noise
	task automatic queue_random(input int count);
		int sw, sh, mw, mh, lft, tp, wv, hv, rad;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				queue_rect($signed(14'($urandom)), $signed(14'($urandom)),
					$signed(14'($urandom)), $signed(14'($urandom)), 10'($urandom));
			end else begin
				sw = (scr_w == 0) ? 1 : int'(scr_w);
				sh = (scr_h == 0) ? 1 : int'(scr_h);
				mw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 300);
				mh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 300);
				lft = int'($urandom_range(0, sw + 60)) - 30;
				tp = int'($urandom_range(0, sh + 60)) - 30;
				wv = mw;
				hv = mh;
				if ($urandom_range(0, 3) == 0) begin
					lft += mw;
					wv = -mw;
				end
				if ($urandom_range(0, 3) == 0) begin
					tp += mh;
					hv = -mh;
				end
				case ($urandom_range(0, 7))
					0: rad = 0;
					1: rad = $urandom_range(rrsg_pkg::MaxRadius + 1, 1023);
					default: rad = $urandom_range(1, rrsg_pkg::MaxRadius);
				endcase
				queue_rect(lft, tp, wv, hv, rad);
			end
		end
	endtask

	task automatic wait_drained();
		while (rects_accepted != rects_queued || span_expect.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset screen 1920x1080
		queue_rect(0, 0, 1920, 1080, rrsg_pkg::MaxRadius);  // full screen, largest radius
		queue_rect(10, 10, 100, 50, 0);                 // no radius: single span
		queue_rect(200, 40, -100, 50, 10);              // negative width
		queue_rect(40, 200, 80, -60, 12);               // negative height
		queue_rect(300, 300, -90, -70, 20);             // both negative
		queue_rect(50, 50, 0, 40, 5);                   // zero width
		queue_rect(50, 50, 40, 0, 5);                   // zero height
		queue_rect(-500, 20, 100, 30, 4);               // off the left
		queue_rect(1920, 20, 100, 30, 4);               // off the right
		queue_rect(20, 1080, 30, 30, 4);                // off the bottom
		queue_rect(-50, -20, 120, 80, 25);              // clipped at left and top
		queue_rect(1900, 1070, 100, 100, 5);            // clipped, side bands collapse
		queue_rect(60, 60, 7, 100, 30);                 // radius bound by half width
		queue_rect(60, 60, 6, 100, 30);                 // centre column collapses
		queue_rect(5, 5, 1, 1, 5);                      // single pixel
		queue_rect(-8192, -8192, -8192, -8192, 1023);
		queue_rect(8191, 8191, 8191, 8191, 1023);
		queue_rect(-4000, -4000, 8191, 8191, 1023);
		queue_rect(0, 0, 2, 2, 1);
		queue_rect(400, 400, 200, 200, rrsg_pkg::MaxRadius + 1);  // saturated radius
		queue_rect(1919, 1079, 1, 1, 0);
		queue_random(150);
		wait_drained();

		write_reg(rrsg_pkg::RegScreenWidth, 12'd4095);
		write_reg(rrsg_pkg::RegScreenHeight, 12'd4095);
		queue_rect(0, 0, 8191, 8191, 0);
		queue_rect(0, 0, 8191, 8191, rrsg_pkg::MaxRadius);
		queue_rect(4094, 4094, 1, 1, 3);
		queue_random(100);
		wait_drained();

		// zero registers act as a 1x1 screen
		write_reg(rrsg_pkg::RegScreenWidth, 12'd0);
		write_reg(rrsg_pkg::RegScreenHeight, 12'd0);
		queue_rect(-10, -10, 50, 50, 20);
		queue_random(40);
		wait_drained();

		write_reg(rrsg_pkg::RegScreenWidth, 12'd1);
		write_reg(rrsg_pkg::RegScreenHeight, 12'd4095);
		queue_random(40);
		wait_drained();

		write_reg(rrsg_pkg::RegScreenWidth, 12'd100);
		write_reg(rrsg_pkg::RegScreenHeight, 12'd64);
		queue_random(50);
		wait_drained();

		write_reg(rrsg_pkg::RegScreenWidth, 12'd640);
		write_reg(rrsg_pkg::RegScreenHeight, 12'd480);
		write_reg(RegSpareA, 12'hFFF);
		write_reg(RegSpareB, 12'h000);
		idling <= 1'b0;
		queue_random(80);
		wait_drained();

		if (span_expect.size() != 0)
			note_fault($sformatf("%0d spans never arrived", span_expect.size()));
		$display("covered %0d rectangles (%0d clipped to nothing) over six screen settings,",
			rects_accepted, rects_clipped_away);
		$display("%0d span beats checked, %0d register writes, %0d faults",
			spans_checked, cfg_writes, faults);
		if (faults == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
